FILE: design/lfd_pkg.sv
// Shared types, codes and constants for the line and frame deframer.
package lfd_pkg;

	localparam int LENGTH_BITS_DEF = 24;
	localparam logic [31:0] MAX_RESET = 32'd10485760;

	localparam logic [7:0] ASCII_CR = 8'd13;
	localparam logic [7:0] ASCII_LF = 8'd10;

	// request codes
	localparam logic [1:0] REQ_DATA  = 2'd0;
	localparam logic [1:0] REQ_LINE  = 2'd1;
	localparam logic [1:0] REQ_FRAME = 2'd2;

	// line styles
	localparam logic [1:0] STYLE_CR_OR_LF = 2'd0;
	localparam logic [1:0] STYLE_STRICT   = 2'd1;
	localparam logic [1:0] STYLE_BREAK    = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNCLAIMED = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;

	// register indexes
	localparam logic [1:0] REG_LINE_STYLE = 2'd0;
	localparam logic [1:0] REG_BREAK_CHAR = 2'd1;
	localparam logic [1:0] REG_MAX_BYTES  = 2'd2;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_LINE  = 2'd1,
		MODE_FRAME = 2'd2
	} mode_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  data_byte;
		logic [23:0] frame_size;
	} rx_item_t;

	typedef struct packed {
		logic        byte_valid;
		logic [7:0]  out_byte;
		logic        end_of_message;
		logic [1:0]  status;
	} tx_item_t;

	typedef struct packed {
		logic [1:0]  reg_index;
		logic [23:0] wdata;
	} cfg_write_t;

endpackage

FILE: design/lfd_chan_if.sv
// Valid/ready channel interface carrying one payload of type T.
interface lfd_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

FILE: design/line_and_frame_deframer.sv
// Line and frame deframer: splits a byte stream into line or length-framed messages.
// Flow: a request accepted on rx is held in the input stage register; once the
//   queue has room for two results it is processed and its results enter the result queue.
// Throughput: one request per cycle while the queue holds two results or fewer; a request
//   giving two results still fits, the 4-entry result queue absorbs the extra one and is the only limit on rx.ready.
// Reset (arst_n, async low): idle mode, empty queue, registers to defaults.
module line_and_frame_deframer #(
	parameter int LENGTH_BITS = lfd_pkg::LENGTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lfd_chan_if.sink   rx,
	lfd_chan_if.source tx,
	lfd_chan_if.sink   cfg
);
	import lfd_pkg::*;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// ---------------------------------------------------------------
	// Configuration registers, written any cycle
	// ---------------------------------------------------------------
	logic [1:0]             line_style_q;
	logic [7:0]             break_char_q;
	logic [LENGTH_BITS-1:0] max_bytes_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_style_q <= STYLE_CR_OR_LF;
			break_char_q <= ASCII_LF;
			max_bytes_q  <= LENGTH_BITS'(MAX_RESET);
		end else if (cfg.valid) begin
			case (cfg.payload.reg_index)
				REG_LINE_STYLE: line_style_q <= cfg.payload.wdata[1:0];
				REG_BREAK_CHAR: break_char_q <= cfg.payload.wdata[7:0];
				REG_MAX_BYTES:  max_bytes_q  <= LENGTH_BITS'(32'(cfg.payload.wdata));
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Input stage register
	// ---------------------------------------------------------------
	logic     valid_s1;
	rx_item_t req_s1;
	logic     fire_s1;
	logic [QPTR_W:0] q_cnt_q;

	// process only when the queue has room for two results
	assign fire_s1  = valid_s1 && (q_cnt_q <= (QPTR_W+1)'(QDEPTH - 2));
	assign rx.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			req_s1 <= rx.payload;
		end
	end

	// ---------------------------------------------------------------
	// Deframer state
	// ---------------------------------------------------------------
	mode_t                  mode_q, mode_d;
	logic                   crlf_seen_q, crlf_seen_d;  // CR ended last line (style 0)
	logic                   held_valid_q, held_valid_d;
	logic [7:0]             held_byte_q, held_byte_d;
	logic                   cr_pending_q, cr_pending_d; // strict CR awaiting LF
	logic [LENGTH_BITS-1:0] bytes_left_q, bytes_left_d;
	logic [LENGTH_BITS-1:0] msg_count_q, msg_count_d;

	tx_item_t res [2];
	logic [1:0] n_res;

	function automatic tx_item_t mk(logic v, logic [7:0] b, logic e, logic [1:0] st);
		tx_item_t r;
		r.byte_valid     = v;
		r.out_byte       = b;
		r.end_of_message = e;
		r.status         = st;
		return r;
	endfunction

	always_comb begin
		logic [7:0]             b;
		logic [LENGTH_BITS-1:0] len_m;
		logic [LENGTH_BITS-1:0] left_m1;
		logic [1:0]             push_v;
		logic [7:0]             push_b [2];
		logic                   end_line;
		logic                   ovf;

		b        = req_s1.data_byte;
		len_m    = LENGTH_BITS'(32'(req_s1.frame_size));
		left_m1  = bytes_left_q - 1'b1;
		push_v   = 2'b00;
		push_b[0] = 8'd0;
		push_b[1] = 8'd0;
		end_line = 1'b0;
		ovf      = 1'b0;

		mode_d       = mode_q;
		crlf_seen_d  = crlf_seen_q;
		held_valid_d = held_valid_q;
		held_byte_d  = held_byte_q;
		cr_pending_d = cr_pending_q;
		bytes_left_d = bytes_left_q;
		msg_count_d  = msg_count_q;
		res[0] = '0;
		res[1] = '0;
		n_res  = 2'd0;

		if (fire_s1) begin
			case (req_s1.req_type)
				REQ_LINE: begin
					held_valid_d = 1'b0;
					held_byte_d  = 8'd0;
					cr_pending_d = 1'b0;
					msg_count_d  = '0;
					mode_d       = MODE_LINE;
				end
				REQ_FRAME: begin
					held_valid_d = 1'b0;
					held_byte_d  = 8'd0;
					cr_pending_d = 1'b0;
					msg_count_d  = '0;
					if (len_m > max_bytes_q) begin
						res[0] = mk(1'b0, 8'd0, 1'b1, ST_OVERFLOW);
						n_res  = 2'd1;
						mode_d = MODE_IDLE;
					end else if (len_m == '0) begin
						res[0] = mk(1'b0, 8'd0, 1'b1, ST_OK);
						n_res  = 2'd1;
						mode_d = MODE_IDLE;
					end else begin
						bytes_left_d = len_m;
						mode_d       = MODE_FRAME;
					end
				end
				REQ_DATA: begin
					case (mode_q)
						MODE_LINE: begin
							case (line_style_q)
								STYLE_STRICT: begin
									if (cr_pending_q && b == ASCII_LF) begin
										end_line = 1'b1;
									end else begin
										// a lone CR becomes payload ahead of this byte
										cr_pending_d = 1'b0;
										if (cr_pending_q) begin
											push_v[0] = 1'b1;
											push_b[0] = ASCII_CR;
										end
										if (b == ASCII_CR) begin
											cr_pending_d = 1'b1;
										end else begin
											push_v[1] = 1'b1;
											push_b[1] = b;
										end
									end
								end
								STYLE_BREAK: begin
									if (b == break_char_q) begin
										end_line = 1'b1;
									end else begin
										push_v[0] = 1'b1;
										push_b[0] = b;
									end
								end
								default: begin
									if (crlf_seen_q && b == ASCII_LF) begin
										crlf_seen_d = 1'b0;
									end else if (b == ASCII_CR) begin
										crlf_seen_d = 1'b1;
										end_line    = 1'b1;
									end else if (b == ASCII_LF) begin
										crlf_seen_d = 1'b0;
										end_line    = 1'b1;
									end else begin
										crlf_seen_d = 1'b0;
										push_v[0]   = 1'b1;
										push_b[0]   = b;
									end
								end
							endcase
						end
						MODE_FRAME: begin
							crlf_seen_d = 1'b0;
							// skip an LF left over from a CR-ended line
							if (!(crlf_seen_q && b == ASCII_LF)) begin
								bytes_left_d = left_m1;
								res[0] = mk(1'b1, b, left_m1 == '0, ST_OK);
								n_res  = 2'd1;
								if (left_m1 == '0) begin
									mode_d = MODE_IDLE;
								end
							end
						end
						default: begin
							res[0] = mk(1'b0, b, 1'b0, ST_UNCLAIMED);
							n_res  = 2'd1;
						end
					endcase
				end
				default: ;
			endcase

			if (end_line) begin
				res[0] = mk(held_valid_q, held_valid_q ? held_byte_q : 8'd0, 1'b1, ST_OK);
				n_res  = 2'd1;
				held_valid_d = 1'b0;
				held_byte_d  = 8'd0;
				cr_pending_d = 1'b0;
				msg_count_d  = '0;
			end

			// holdback: up to two payload bytes, the first overflow stops the rest
			for (int k = 0; k < 2; k++) begin
				if (push_v[k] && !ovf) begin
					if (msg_count_d >= max_bytes_q) begin
						ovf = 1'b1;
						res[n_res[0]] = mk(1'b0, 8'd0, 1'b1, ST_OVERFLOW);
						n_res = n_res + 2'd1;
						held_valid_d = 1'b0;
						held_byte_d  = 8'd0;
						cr_pending_d = 1'b0;
						msg_count_d  = '0;
						mode_d       = MODE_IDLE;
					end else begin
						msg_count_d = msg_count_d + 1'b1;
						if (held_valid_d) begin
							res[n_res[0]] = mk(1'b1, held_byte_d, 1'b0, ST_OK);
							n_res = n_res + 2'd1;
						end
						held_byte_d  = push_b[k];
						held_valid_d = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			crlf_seen_q  <= 1'b0;
			held_valid_q <= 1'b0;
			held_byte_q  <= 8'd0;
			cr_pending_q <= 1'b0;
			bytes_left_q <= '0;
			msg_count_q  <= '0;
		end else begin
			mode_q       <= mode_d;
			crlf_seen_q  <= crlf_seen_d;
			held_valid_q <= held_valid_d;
			held_byte_q  <= held_byte_d;
			cr_pending_q <= cr_pending_d;
			bytes_left_q <= bytes_left_d;
			msg_count_q  <= msg_count_d;
		end
	end

	// ---------------------------------------------------------------
	// Result queue: takes up to two results a cycle, gives one
	// ---------------------------------------------------------------
	tx_item_t          q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] q_wr_q, q_rd_q;
	logic              pop;
	logic [1:0]        n_push;

	assign n_push    = fire_s1 ? n_res : 2'd0;
	assign pop       = tx.valid && tx.ready;
	assign tx.valid  = (q_cnt_q != '0);
	assign tx.payload = q_mem_q[q_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q  <= '0;
			q_rd_q  <= '0;
			q_cnt_q <= '0;
		end else begin
			q_wr_q  <= q_wr_q + QPTR_W'(n_push);
			q_rd_q  <= q_rd_q + QPTR_W'(pop);
			q_cnt_q <= q_cnt_q + (QPTR_W+1)'(n_push) - (QPTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			q_mem_q[q_wr_q] <= res[0];
		end
		if (n_push == 2'd2) begin
			q_mem_q[q_wr_q + 1'b1] <= res[1];
		end
	end

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_cnt_q <= (QPTR_W+1)'(QDEPTH))
		else $error("result queue overfilled");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IDLE |-> !held_valid_q && !cr_pending_q)
		else $error("idle with a held byte or pending CR");

	a_frame_left: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_FRAME |-> bytes_left_q != '0)
		else $error("frame mode with nothing left");

	a_held_counted: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> msg_count_q != '0)
		else $error("held byte not counted");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_cnt_q > (QPTR_W+1)'(QDEPTH - 2) |=> q_cnt_q <= $past(q_cnt_q))
		else $error("queue grew while nearly full");

endmodule
